// ===== sv/vt52_pkg.sv =====
// Shared types, command codes and the graphics glyph table of the VT52 decoder.
package vt52_pkg;

	localparam int FifoDepth = 4;

	typedef logic [4:0] cmd_t;

	localparam cmd_t CmdPrint      = 5'd0;
	localparam cmd_t CmdAnswerback = 5'd1;
	localparam cmd_t CmdBackspace  = 5'd2;
	localparam cmd_t CmdTab        = 5'd3;
	localparam cmd_t CmdUp         = 5'd4;
	localparam cmd_t CmdDown       = 5'd5;
	localparam cmd_t CmdRight      = 5'd6;
	localparam cmd_t CmdLeft       = 5'd7;
	localparam cmd_t CmdClearHome  = 5'd8;
	localparam cmd_t CmdHome       = 5'd9;
	localparam cmd_t CmdRevLf      = 5'd10;
	localparam cmd_t CmdEraseEos   = 5'd11;
	localparam cmd_t CmdEraseEol   = 5'd12;
	localparam cmd_t CmdPosition   = 5'd13;
	localparam cmd_t CmdIdentify   = 5'd14;
	localparam cmd_t CmdKeypadAlt  = 5'd15;
	localparam cmd_t CmdKeypadNum  = 5'd16;
	localparam cmd_t CmdHoldOn     = 5'd17;
	localparam cmd_t CmdHoldOff    = 5'd18;

	typedef struct packed {
		cmd_t        command;
		logic [15:0] code_point;
		logic [6:0]  row;
		logic [6:0]  column;
		logic        last;
	} result_t;

	// Which of the two result slots carry a result for this byte.
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

	// VT52 graphics set for characters 0x5E..0x7E, index = char - 0x5E.
	function automatic logic [15:0] gfx_glyph(input logic [5:0] idx);
		logic [15:0] g;
		case (idx)
			6'd0, 6'd1, 6'd2:    g = 16'h0020;
			6'd3:                g = 16'h2592;
			6'd4:                g = 16'h215F;
			6'd5, 6'd6, 6'd7:    g = 16'h2591;
			6'd8:                g = 16'h00B0;
			6'd9:                g = 16'h00B1;
			6'd10:               g = 16'h2192;
			6'd11:               g = 16'h2026;
			6'd12:               g = 16'h00F7;
			6'd13:               g = 16'h2193;
			6'd14, 6'd15:        g = 16'h23BA;
			6'd16, 6'd17:        g = 16'h23BB;
			6'd18, 6'd19:        g = 16'h2500;
			6'd20, 6'd21:        g = 16'h23BC;
			6'd22:               g = 16'h2080;
			6'd23:               g = 16'h2081;
			6'd24:               g = 16'h2082;
			6'd25:               g = 16'h2083;
			6'd26:               g = 16'h2084;
			6'd27:               g = 16'h2085;
			6'd28:               g = 16'h2086;
			6'd29:               g = 16'h2087;
			6'd30:               g = 16'h2088;
			6'd31:               g = 16'h2089;
			6'd32:               g = 16'h00B6;
			default:             g = 16'h0020;
		endcase
		return g;
	endfunction

endpackage

// ===== sv/vt52_decode.sv =====
// Escape sequence state machine and per-byte result decode.
module vt52_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [6:0]        ch,
	output vt52_pkg::push_t   push,
	output vt52_pkg::result_t res0,
	output vt52_pkg::result_t res1
);
	import vt52_pkg::*;

	typedef enum logic [3:0] {
		PhIdle = 4'b0001,
		PhEsc  = 4'b0010,
		PhRow  = 4'b0100,
		PhCol  = 4'b1000
	} phase_t;

	localparam logic [6:0] ChEnq       = 7'h05;
	localparam logic [6:0] ChBs        = 7'h08;
	localparam logic [6:0] ChTab       = 7'h09;
	localparam logic [6:0] ChEsc       = 7'h1B;
	localparam logic [6:0] ChSpace     = 7'h20;
	localparam logic [6:0] ChDel       = 7'h7F;
	localparam logic [6:0] ChGfxLo     = 7'h5E;
	localparam logic [6:0] ChGfxHi     = 7'h7E;
	localparam logic [6:0] ChA         = 7'h41;
	localparam logic [6:0] ChB         = 7'h42;
	localparam logic [6:0] ChC         = 7'h43;
	localparam logic [6:0] ChD         = 7'h44;
	localparam logic [6:0] ChE         = 7'h45;
	localparam logic [6:0] ChF         = 7'h46;
	localparam logic [6:0] ChG         = 7'h47;
	localparam logic [6:0] ChH         = 7'h48;
	localparam logic [6:0] ChI         = 7'h49;
	localparam logic [6:0] ChJ         = 7'h4A;
	localparam logic [6:0] ChK         = 7'h4B;
	localparam logic [6:0] ChY         = 7'h59;
	localparam logic [6:0] ChZ         = 7'h5A;
	localparam logic [6:0] ChKeyAlt    = 7'h3D;
	localparam logic [6:0] ChKeyNum    = 7'h3E;
	localparam logic [6:0] ChLBracket  = 7'h5B;
	localparam logic [6:0] ChBackslash = 7'h5C;

	phase_t     phase_q, phase_d;
	logic       graphics_q, graphics_d;
	logic       keypad_q, keypad_d;
	logic [6:0] row_byte_q, row_byte_d;
	logic [6:0] gfx_off;
	logic [15:0] glyph;

	function automatic logic [6:0] clamp_pos(input logic [6:0] b);
		return (b >= ChSpace) ? (b - ChSpace) : 7'd0;
	endfunction

	assign gfx_off = ch - ChGfxLo;
	assign glyph = (graphics_q && ch >= ChGfxLo && ch <= ChGfxHi)
		? gfx_glyph(gfx_off[5:0]) : {9'd0, ch};

	always_comb begin
		phase_d    = phase_q;
		graphics_d = graphics_q;
		keypad_d   = keypad_q;
		row_byte_d = row_byte_q;
		push       = '0;
		res0       = '0;
		res1       = '0;
		res0.last  = 1'b1;
		res1.last  = 1'b1;
		unique case (phase_q)
			PhIdle: begin
				if (ch == ChEsc) begin
					phase_d = PhEsc;
				end else if (ch == ChEnq) begin
					push.first = 1'b1;
					res0.command = CmdAnswerback;
				end else if (ch == ChBs) begin
					push.first = 1'b1;
					res0.command = CmdBackspace;
				end else if (ch == ChTab) begin
					push.first = 1'b1;
					res0.command = CmdTab;
				end else if (ch >= ChSpace && ch != ChDel) begin
					push.first = 1'b1;
					res0.command = CmdPrint;
					res0.code_point = glyph;
				end
			end
			PhRow: begin
				row_byte_d = ch;
				phase_d = PhCol;
			end
			PhCol: begin
				push.first = 1'b1;
				res0.command = CmdPosition;
				res0.row = clamp_pos(row_byte_q);
				res0.column = clamp_pos(ch);
				row_byte_d = '0;
				phase_d = PhIdle;
			end
			PhEsc: begin
				phase_d = PhIdle;
				push.first = 1'b1;
				unique case (ch)
					ChA:         res0.command = CmdUp;
					ChB:         res0.command = CmdDown;
					ChC:         res0.command = CmdRight;
					ChD:         res0.command = CmdLeft;
					ChE:         res0.command = CmdClearHome;
					ChH:         res0.command = CmdHome;
					ChI:         res0.command = CmdRevLf;
					ChJ:         res0.command = CmdEraseEos;
					ChK:         res0.command = CmdEraseEol;
					ChZ:         res0.command = CmdIdentify;
					ChLBracket:  res0.command = CmdHoldOn;
					ChBackslash: res0.command = CmdHoldOff;
					ChF: begin
						graphics_d = 1'b1;
						push.first = 1'b0;
					end
					ChG: begin
						graphics_d = 1'b0;
						push.first = 1'b0;
					end
					ChY: begin
						phase_d = PhRow;
						push.first = 1'b0;
					end
					ChKeyAlt: begin
						keypad_d = 1'b1;
						res0.command = CmdKeypadAlt;
					end
					ChKeyNum: begin
						keypad_d = 1'b0;
						res0.command = CmdKeypadNum;
					end
					default: begin
						// unknown escape: replay ESC, then the byte unmapped
						push.second = 1'b1;
						res0.command = CmdPrint;
						res0.code_point = {9'd0, ChEsc};
						res0.last = 1'b0;
						res1.command = CmdPrint;
						res1.code_point = {9'd0, ch};
					end
				endcase
			end
			default: phase_d = PhIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PhIdle;
			graphics_q <= 1'b0;
			keypad_q   <= 1'b0;
			row_byte_q <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			graphics_q <= graphics_d;
			keypad_q   <= keypad_d;
			row_byte_q <= row_byte_d;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PhEsc && ch == ChKeyAlt) |=> keypad_q)
		else $error("keypad mode not set by ESC =");
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PhCol) |=> (row_byte_q == '0 && phase_q == PhIdle))
		else $error("position sequence did not return to idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && phase_q == PhEsc && ch == ChY) |=> phase_q == PhRow)
		else $error("ESC Y did not enter row phase");
	assert property (@(posedge clk) disable iff (!arst_n)
		push.second |-> push.first)
		else $error("second result without first");
`endif
endmodule

// ===== sv/vt52_result_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per transfer.
module vt52_result_fifo #(
	parameter int Depth = vt52_pkg::FifoDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  vt52_pkg::push_t   push,
	input  vt52_pkg::result_t din0,
	input  vt52_pkg::result_t din1,
	output logic              room,
	output logic              out_valid,
	input  logic              out_stall,
	output vt52_pkg::result_t dout
);
	import vt52_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	result_t           mem_q [Depth];
	logic [PtrW-1:0]   wr_q, rd_q, wr1, wr2, rd1;
	logic [CntW-1:0]   cnt_q;
	logic [1:0]        npush;
	logic              pop;

	function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign wr1 = nxt(wr_q);
	assign wr2 = nxt(wr1);
	assign rd1 = nxt(rd_q);
	assign npush = {1'b0, push.first} + {1'b0, push.second};
	assign room = (cnt_q <= CntW'(Depth - 2));
	assign out_valid = (cnt_q != '0);
	assign pop = out_valid && !out_stall;
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.first) begin
			mem_q[wr_q] <= din0;
		end
		if (push.second) begin
			mem_q[wr1] <= din1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.second) begin
				wr_q <= wr2;
			end else if (push.first) begin
				wr_q <= wr1;
			end
			if (pop) begin
				rd_q <= rd1;
			end
			cnt_q <= cnt_q + CntW'(npush) - CntW'(pop);
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(Depth))
		else $error("result queue overflow");
`endif
endmodule

// ===== sv/vt52_escape_decoder_unit.sv =====
// Top level of the VT52 receive decoder: input stage, decode and result queue.
//
// VT52 receive decoder. Each byte taken on the input channel (bit 7 ignored)
// is decoded as VT52 terminal traffic into zero, one or two result transfers
// carrying a display command, a code point for printed characters, a clamped
// row and column for ESC Y, and a last flag on the final result of each byte.
// The byte is held in one input register; the escape state machine and
// glyph table decode it there combinationally and push its results into a
// small result queue, which drives the output channel. One byte is taken
// every cycle as long as the queue has room for two more results; a byte
// waits in the input register until then, and its results are registered
// in the queue before they reach the output. Queue depth is the FIFO_DEPTH
// parameter (at least 2; the default of 4 sustains one byte per cycle when
// the output side keeps up). Bytes that cause no result (control bytes, DEL,
// escape prefixes, ESC F / ESC G, the row byte of ESC Y) still wait for room.
module vt52_escape_decoder_unit #(
	parameter int FIFO_DEPTH = vt52_pkg::FifoDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// result output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  command,
	output logic [15:0] code_point,
	output logic [6:0]  row,
	output logic [6:0]  column,
	output logic        last
);
	import vt52_pkg::*;

	logic       valid_s1;
	logic [6:0] byte_s1;
	logic       room;
	logic       advance;
	logic       in_xfer;
	push_t      dec_push;
	push_t      fifo_push;
	result_t    res0, res1, head;

	// The byte in the input register is decoded once the queue can absorb
	// up to two results; a new transfer is taken when the register is free
	// or is being emptied in the same cycle.
	assign advance  = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// bit 7 is dropped on the way in
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1 <= rx_byte[6:0];
		end
	end

	vt52_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.ch      (byte_s1),
		.push    (dec_push),
		.res0    (res0),
		.res1    (res1)
	);

	assign fifo_push.first  = advance && dec_push.first;
	assign fifo_push.second = advance && dec_push.second;

	vt52_result_fifo #(
		.Depth (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.din0      (res0),
		.din1      (res1),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (head)
	);

	assign command    = head.command;
	assign code_point = head.code_point;
	assign row        = head.row;
	assign column     = head.column;
	assign last       = head.last;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("held byte lost before decode");
`endif
endmodule
